/* src/mbavg_pkg.sv */
package mbavg_pkg;

  // Widths fixed by the result and register fields.
  localparam int CHANNEL_BITS   = 3;
  localparam int COUNT_BITS     = 8;
  // Headroom so a full run of up to 255 conversions never overflows a sum.
  localparam int SUM_GUARD_BITS = 8;

  typedef logic [CHANNEL_BITS-1:0] channel_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

endpackage

/* src/mbavg_if.sv */
interface mbavg_in_if import mbavg_pkg::*; #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mbavg_out_if import mbavg_pkg::*; #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  channel_t                      channel;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          last;

  modport source (output valid, output channel, output average, output last, input ready);
  modport sink   (input valid, input channel, input average, input last, output ready);
endinterface

interface mbavg_cfg_if import mbavg_pkg::*;;
  logic   valid;
  logic   ready;
  count_t avg_count;

  modport source (output valid, output avg_count, input ready);
  modport sink   (input valid, input avg_count, output ready);
endinterface

/* src/mbavg_ram.sv */
module mbavg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mbavg_div.sv */
// Signed-by-unsigned divide, truncating toward zero.
// Restoring, one quotient bit per cycle while busy after start.
module mbavg_div import mbavg_pkg::*; #(
  parameter int SUM_W = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  count_t                  divisor,
  output logic                    busy,
  output logic [SUM_W-1:0]        q_mag,
  output logic                    q_neg
);

  localparam int CW = $clog2(SUM_W + 1);

  logic [COUNT_BITS-1:0] rem;
  count_t                dvs;
  logic [CW-1:0]         cnt;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem, q_mag[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // q_mag holds the dividend magnitude and shifts the quotient in behind it
  always_ff @(posedge clk) begin
    if (start) begin
      q_neg <= dividend[SUM_W-1];
      q_mag <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      q_mag <= {q_mag[SUM_W-2:0], fits};
      rem   <= fits ? COUNT_BITS'(trial - {1'b0, dvs}) : trial[COUNT_BITS-1:0];
    end
  end

endmodule

/* src/multichannel_block_averager_top.sv */
// Multichannel block averager.
// samples: one signed code per transaction, channels in order 0 .. CHANNELS-1,
//   then back to 0. Each code is added into its channel's sum held in a RAM.
// cfg: one write sets avg_count (0 acts as 1); write it only while idle.
// results: after avg_count complete conversions, CHANNELS transactions follow,
//   channel 0 first, each carrying sum / avg_count truncated toward zero and
//   saturated to the sample range; last marks the final channel.
// Samples: each one is read from the RAM, then added and written back, and the
//   next sample is not taken until that write-back is done. At a run end, per
//   channel: a RAM read, a divider start, a wait on the bit-serial divider
//   (SAMPLE_BITS + 8 shifts), and a load of the output register. Samples are
//   not taken during that emission.
// Stalls: the output register holds a result until taken; the next channel's
//   divide waits for it. Once the last result is loaded, samples are taken
//   again even if that result is still pending.
// Reset: sums, channel position and conversion count clear, avg_count goes
//   to 1. A clearing pass writes zero to every RAM entry before the first
//   sample is taken; cfg writes are taken throughout.
module multichannel_block_averager_top import mbavg_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  mbavg_in_if.sink    samples,
  mbavg_out_if.source results,
  mbavg_cfg_if.sink   cfg
);

  localparam int SUM_W = SAMPLE_BITS + SUM_GUARD_BITS;
  localparam int IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);
  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(1 << (SAMPLE_BITS - 1));

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                    state;
  logic [IW-1:0]                 pos;
  logic [IW-1:0]                 idx;
  count_t                        conv_done;
  count_t                        avg_count;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic                          out_valid;
  channel_t                      out_channel;
  logic signed [SAMPLE_BITS-1:0] out_average;
  logic                          out_last;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [SUM_W-1:0]        ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [SUM_W-1:0]        ram_rdata;

  count_t                  divisor;
  logic [COUNT_BITS:0]     conv_inc;
  logic                    run_end;
  logic [SUM_W-1:0]        sum_new;
  logic                    div_start;
  logic                    div_busy;
  logic [SUM_W-1:0]        q_mag;
  logic                    q_neg;
  logic [SUM_W-1:0]        q_negated;
  logic [SAMPLE_BITS-1:0]  avg_sat;
  logic                    accept;
  logic                    out_load;

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  assign results.valid   = out_valid;
  assign results.channel = out_channel;
  assign results.average = out_average;
  assign results.last    = out_last;

  assign divisor   = (avg_count == '0) ? COUNT_BITS'(1) : avg_count;
  assign conv_inc  = {1'b0, conv_done} + 1'b1;
  assign run_end   = conv_inc >= {1'b0, divisor};
  assign sum_new   = ram_rdata + SUM_W'(sample_q);
  assign div_start = (state == ST_LOAD);
  assign out_load  = (state == ST_OUT) && (!out_valid || results.ready);
  assign q_negated = ~q_mag + 1'b1;

  always_comb begin
    if (!q_neg) begin
      avg_sat = (q_mag > POS_LIM) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : q_mag[SAMPLE_BITS-1:0];
    end else begin
      avg_sat = (q_mag > NEG_LIM) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : q_negated[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = (state == ST_IDLE) ? pos : idx;
    unique case (state)
      ST_CLEAR: ram_we = 1'b1;
      ST_ACC: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = sum_new;
      end
      // sum goes to the divider this cycle, so the entry can clear now
      ST_LOAD:  ram_we = 1'b1;
      default:  ram_we = 1'b0;
    endcase
  end

  mbavg_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mbavg_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (divisor),
    .busy     (div_busy),
    .q_mag    (q_mag),
    .q_neg    (q_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count <= COUNT_BITS'(1);
    end else if (cfg.valid && cfg.ready) begin
      avg_count <= cfg.avg_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pos       <= '0;
      idx       <= '0;
      conv_done <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          state <= ST_IDLE;
          if (pos == LAST_IDX) begin
            pos <= '0;
            if (run_end) begin
              conv_done <= '0;
              idx       <= '0;
              state     <= ST_READ;
            end else begin
              conv_done <= conv_inc[COUNT_BITS-1:0];
            end
          end else begin
            pos <= pos + 1'b1;
          end
        end
        ST_READ: state <= ST_LOAD;
        ST_LOAD: state <= ST_WAIT;
        ST_WAIT: begin
          if (!div_busy) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= samples.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= CHANNEL_BITS'(idx);
      out_average <= avg_sat;
      out_last    <= (idx == LAST_IDX);
    end
  end

endmodule

/* src/mbavg_chk.sv */
module mbavg_chk import mbavg_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input channel_t                      out_channel,
  input logic signed [SAMPLE_BITS-1:0] out_average,
  input logic                          out_last
);

  localparam channel_t LAST_CH = CHANNEL_BITS'(CHANNELS - 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel)
      && $stable(out_average) && $stable(out_last))
    else $error("stalled result changed");

  // last only on the final channel
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_channel == LAST_CH)
    else $error("last on wrong channel");

  // the cycle after a sample is taken, its read-modify-write blocks the next one
  a_rmw_interlock: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken during sum update");

  // result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind multichannel_block_averager_top mbavg_chk #(
  .CHANNELS    (CHANNELS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mbavg_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_channel (results.channel),
  .out_average (results.average),
  .out_last    (results.last)
);

/* tb/multichannel_block_averager_checker.sv */
`timescale 1ns / 1ps

module multichannel_block_averager_checker import mbavg_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  mbavg_in_if  samples,
  mbavg_out_if results,
  mbavg_cfg_if cfg,
  output int   open_results,
  output int   failures
);

  localparam longint AVERAGE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint AVERAGE_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef struct {
    channel_t                      channel;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          last;
  } channel_average_t;

  channel_average_t averages_due[$];
  longint           channel_sum[CHANNELS];
  int unsigned      next_channel;
  int unsigned      runs_summed;
  count_t           avg_count;

  function automatic logic signed [SAMPLE_BITS-1:0] saturate(input longint value);
    longint clipped;
    clipped = (value > AVERAGE_MAX) ? AVERAGE_MAX :
              (value < AVERAGE_MIN) ? AVERAGE_MIN : value;
    return clipped[SAMPLE_BITS-1:0];
  endfunction

  task automatic accumulate(input logic signed [SAMPLE_BITS-1:0] code);
    int unsigned      divisor;
    channel_average_t avg;
    // a count of zero behaves as one
    divisor = (avg_count == '0) ? 1 : avg_count;
    channel_sum[next_channel] += code;
    if (next_channel + 1 < CHANNELS) begin
      next_channel++;
    end else begin
      next_channel = 0;
      // count may have been lowered mid-run: the run ends as soon as it is reached
      if (runs_summed + 1 < divisor) begin
        runs_summed++;
      end else begin
        for (int k = 0; k < CHANNELS; k++) begin
          avg.channel = channel_t'(k);
          avg.average = saturate(channel_sum[k] / longint'(divisor));
          avg.last    = (k == CHANNELS - 1);
          averages_due.push_back(avg);
          channel_sum[k] = 0;
        end
        runs_summed = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    channel_average_t want;
    if (rst) begin
      foreach (channel_sum[k]) channel_sum[k] = 0;
      next_channel = 0;
      runs_summed  = 0;
      avg_count    = count_t'(1);
      failures     = 0;
      averages_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        avg_count = cfg.avg_count;
      end
      if (samples.valid && samples.ready) begin
        accumulate(samples.sample);
      end
      if (results.valid && results.ready) begin
        if (averages_due.size() == 0) begin
          $error("unexpected result transaction: channel %0d average %0d last %0b",
                 results.channel, results.average, results.last);
          failures++;
        end else begin
          want = averages_due.pop_front();
          if (results.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, results.channel);
            failures++;
          end
          if (results.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, results.average);
            failures++;
          end
          if (results.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, results.last);
            failures++;
          end
        end
      end
    end
    // registered so the stimulus side reads a settled value at the edge
    open_results <= averages_due.size();
  end

endmodule

/* tb/multichannel_block_averager_top_tb.sv */
`timescale 1ns / 1ps

module multichannel_block_averager_top_tb;
  import mbavg_pkg::*;

  localparam int CHANNELS      = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = CHANNELS * (SAMPLE_BITS + 12) + 20;
  localparam int LONG_STALL    = 400;
  localparam int STALL_PHASE   = 2;
  localparam count_t COUNT_ONE = 8'd1;
  localparam count_t COUNT_MAX = 8'd255;
  localparam logic signed [SAMPLE_BITS-1:0] CODE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] CODE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk;
  logic rst;
  int   failures;
  int   open_results;
  int   stall_requests = 0;
  bit   tx_idle_on;
  bit   rx_idle_on;

  logic signed [SAMPLE_BITS-1:0] extreme_codes[CHANNELS] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
    16'sh0001, 16'sh5555, 16'shAAAA, 16'sh00FF
  };

  mbavg_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples ();
  mbavg_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) results ();
  mbavg_cfg_if                              cfg ();

  multichannel_block_averager_top #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples),
    .results(results),
    .cfg    (cfg)
  );

  multichannel_block_averager_checker #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) avg_check (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .results     (results),
    .cfg         (cfg),
    .open_results(open_results),
    .failures    (failures)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_code();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return SAMPLE_BITS'($urandom_range(0, 2**SAMPLE_BITS - 1));
    // small values around zero exercise truncation of negative sums
    if (roll < 17) return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
    return $urandom_range(0, 1) ? CODE_MAX : CODE_MIN;
  endfunction

  function automatic count_t random_avg_count();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return COUNT_MAX;
    if (roll < 8)  return COUNT_ONE;
    if (roll < 16) return count_t'($urandom_range(2, 4));
    return count_t'($urandom_range(5, 8));
  endfunction

  // result side: random back-pressure plus an on-demand long hold-off
  initial begin
    int hold_left;
    int stalls_served;
    hold_left     = 0;
    stalls_served = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else if (stalls_served != stall_requests) begin
        stalls_served++;
        hold_left = LONG_STALL - 1;
        results.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        hold_left = idle_gap() - 1;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] code);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid  <= 1'b1;
    samples.sample <= code;
    do @(posedge clk); while (!samples.ready);
  endtask

  // count is only changed once all pending averages are out
  task automatic write_avg_count(input count_t value);
    samples.valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.valid     <= 1'b1;
    cfg.avg_count <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    int     random_sent;
    int     phase;
    int     item_total;
    count_t next_count;

    random_sent = 0;
    phase       = 0;
    rst            <= 1'b1;
    samples.valid  <= 1'b0;
    samples.sample <= '0;
    cfg.valid      <= 1'b0;
    cfg.avg_count  <= COUNT_ONE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // field extremes at the reset count of one
    foreach (extreme_codes[i]) send_sample(extreme_codes[i]);

    // one conversion of full-scale codes toward a count of three, then the
    // count drops to zero (acts as one): the run ends early and saturates
    write_avg_count(8'd3);
    for (int i = 0; i < CHANNELS; i++) send_sample((i % 2 == 0) ? CODE_MAX : CODE_MIN);
    write_avg_count('0);
    for (int i = 0; i < CHANNELS; i++) send_sample((i % 2 == 0) ? CODE_MAX : CODE_MIN);

    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on <= $urandom_range(0, 3) != 0;
      if (phase == 1) begin
        next_count = COUNT_MAX;
        item_total = CHANNELS + 3;
      end else if (phase == STALL_PHASE) begin
        // results blocked while samples keep coming: input must back up
        next_count = COUNT_ONE;
        item_total = 3 * CHANNELS;
        tx_idle_on = 1'b0;
      end else begin
        next_count = random_avg_count();
        item_total = CHANNELS * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) item_total += $urandom_range(1, CHANNELS - 1);
      end
      write_avg_count(next_count);
      if (phase == STALL_PHASE) stall_requests <= stall_requests + 1;
      repeat (item_total) begin
        send_sample(random_code());
        random_sent++;
      end
    end

    samples.valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
